// ===== design/mflg_pkg.sv =====
// mflg_pkg: shared constants, types and codes for the level-graph max-flow block.
// No dependencies.
package mflg_pkg;

	localparam int MAX_NODES = 16;
	localparam int MAX_EDGES = 32;
	localparam int CAP_BITS  = 16;

	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int DEPTH_W   = $clog2(MAX_NODES) + 1;
	localparam int ARC_COUNT = 2 * MAX_EDGES;
	localparam int ARC_AW    = $clog2(ARC_COUNT);
	localparam int ARC_W     = ARC_AW + 1;
	localparam int TN_W      = NODE_W + ARC_W;
	localparam int RES_W     = CAP_BITS + 1;
	localparam int LVL_W     = 5;
	localparam int GOT_W     = 24;
	localparam int FLOW_W    = 22;

	localparam logic [ARC_W-1:0]  NO_ARC    = ARC_W'(ARC_COUNT);
	localparam logic [LVL_W-1:0]  LVL_NONE  = 5'd31;
	localparam logic [LVL_W-1:0]  LVL_DEAD  = 5'd30;
	localparam logic [FLOW_W-1:0] FLOW_MAX  = '1;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	localparam logic [1:0] REG_SOURCE = 2'd0;
	localparam logic [1:0] REG_SINK   = 2'd1;
	localparam logic [1:0] REG_NODES  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  end_a;
		logic [3:0]  end_b;
		logic [15:0] capacity;
	} mflg_req_t;

	typedef struct packed {
		logic [21:0] max_flow;
		logic [5:0]  edge_count;
		logic [1:0]  status;
	} mflg_rsp_t;

	typedef struct packed {
		logic [3:0] source_node;
		logic [3:0] sink_node;
		logic [4:0] node_count;
	} mflg_cfg_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LATCH, OP_DECODE, OP_ADD1, OP_ADD2, OP_CLEAR,
		OP_BFS_INIT, OP_BFS_POP, OP_ARC_RD, OP_BFS_CHK,
		OP_BLK_FRAME, OP_BLK_CHK, OP_ARC_END, OP_POP,
		OP_U_RD1, OP_U_WR1, OP_U_WR2
	} mflg_op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       add_bad;
		logic       add_full;
		logic       run_bad;
		logic       run_same;
		logic       q_empty;
		logic       sink_reached;
		logic       arc_end;
		logic       bfs_new;
		logic       blk_ok;
		logic       v_sink;
		logic       can_push;
		logic       lim_zero;
		logic       last_frame;
	} mflg_stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_ADD1, S_ADD2, S_CLR, S_BFS_INIT, S_BFS_POP,
		S_BFS_ARC, S_BFS_CHK, S_BLK_FRAME, S_BLK_ARC, S_BLK_CHK,
		S_POP, S_U_RD1, S_U_WR1, S_U_WR2, S_RESP
	} mflg_state_t;

endpackage

// ===== design/mflg_ram.sv =====
// mflg_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module mflg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/mflg_dp.sv =====
// mflg_dp: graph storage, BFS queue, search stack and flow arithmetic.
// Depends on mflg_pkg and mflg_ram.
module mflg_dp import mflg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mflg_op_t   op,
	input  mflg_req_t  item,
	input  mflg_cfg_t  cfg,
	output mflg_stat_t stat,
	output mflg_rsp_t  rsp
);
	logic [ARC_W-1:0]   arcs_q;
	logic [ARC_W-1:0]   first_q [MAX_NODES];
	logic [LVL_W-1:0]   level_q [MAX_NODES];
	logic [ARC_W-1:0]   cur_q [MAX_NODES];
	logic [NODE_W-1:0]  queue_q [MAX_NODES];
	logic [NODE_W-1:0]  stk_node_q [MAX_NODES];
	logic [RES_W-1:0]   stk_lim_q [MAX_NODES];
	logic               stk_inf_q [MAX_NODES];
	logic [GOT_W-1:0]   stk_got_q [MAX_NODES];
	logic [DEPTH_W-1:0] depth_q, head_q, tail_q;
	logic [GOT_W-1:0]   sum_q;
	logic [1:0]         status_q;
	mflg_req_t          item_q;
	logic [NODE_W-1:0]  u_q, pn_q;
	logic [LVL_W-1:0]   ulev_q;
	logic [ARC_W-1:0]   a_q, fa_q;
	logic [RES_W-1:0]   d_q;

	logic               tn_we, res_we;
	logic [ARC_AW-1:0]  tn_wa, res_wa, tn_ra, res_ra;
	logic [TN_W-1:0]    tn_wd, tn_rd;
	logic [RES_W-1:0]   res_wd, res_rd;

	logic [DEPTH_W-1:0] nodes;
	logic [NODE_W-1:0]  top;
	logic [NODE_W-1:0]  tgt, pn_c;
	logic [ARC_W-1:0]   nxt, fa_c;
	logic [LVL_W-1:0]   lev_v, ulev1;
	logic [RES_W-1:0]   lim_eff;

	mflg_ram #(.WIDTH(TN_W), .DEPTH(ARC_COUNT)) u_tn_ram (
		.clk(clk), .we(tn_we), .waddr(tn_wa), .wdata(tn_wd), .raddr(tn_ra), .rdata(tn_rd)
	);
	mflg_ram #(.WIDTH(RES_W), .DEPTH(ARC_COUNT)) u_res_ram (
		.clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd)
	);

	always_comb begin
		if (cfg.node_count == '0) begin
			nodes = DEPTH_W'(1);
		end else if (cfg.node_count > DEPTH_W'(MAX_NODES)) begin
			nodes = DEPTH_W'(MAX_NODES);
		end else begin
			nodes = cfg.node_count;
		end
		top     = NODE_W'(depth_q - 1'b1);
		tgt     = tn_rd[TN_W-1:ARC_W];
		nxt     = tn_rd[ARC_W-1:0];
		lev_v   = level_q[tgt];
		ulev1   = ulev_q + 1'b1;
		pn_c    = stk_node_q[top];
		fa_c    = cur_q[pn_c];
		if (stk_inf_q[top] || res_rd < stk_lim_q[top]) begin
			lim_eff = res_rd;
		end else begin
			lim_eff = stk_lim_q[top];
		end
	end

	always_comb begin
		tn_we  = 1'b0;
		res_we = 1'b0;
		tn_wa  = arcs_q[ARC_AW-1:0];
		res_wa = arcs_q[ARC_AW-1:0];
		tn_wd  = {item_q.end_b, first_q[item_q.end_a]};
		res_wd = RES_W'(item_q.capacity);
		tn_ra  = a_q[ARC_AW-1:0];
		res_ra = a_q[ARC_AW-1:0];
		case (op)
			OP_ADD1: begin
				tn_we  = 1'b1;
				res_we = 1'b1;
			end
			OP_ADD2: begin
				tn_we  = 1'b1;
				res_we = 1'b1;
				tn_wd  = {item_q.end_a, first_q[item_q.end_b]};
			end
			OP_U_RD1: begin
				tn_ra  = fa_c[ARC_AW-1:0];
				res_ra = fa_c[ARC_AW-1:0];
			end
			OP_U_WR1: begin
				res_we = 1'b1;
				res_wa = fa_q[ARC_AW-1:0];
				res_wd = res_rd - d_q;
				res_ra = fa_q[ARC_AW-1:0] ^ ARC_AW'(1);
			end
			OP_U_WR2: begin
				res_we = 1'b1;
				res_wa = fa_q[ARC_AW-1:0] ^ ARC_AW'(1);
				res_wd = res_rd + d_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.req_type     = item_q.req_type;
		stat.add_bad      = {1'b0, item_q.end_a} >= nodes || {1'b0, item_q.end_b} >= nodes;
		stat.add_full     = arcs_q > ARC_W'(ARC_COUNT - 2);
		stat.run_bad      = {1'b0, cfg.source_node} >= nodes || {1'b0, cfg.sink_node} >= nodes;
		stat.run_same     = cfg.source_node == cfg.sink_node;
		stat.q_empty      = head_q == tail_q;
		stat.sink_reached = level_q[cfg.sink_node] != LVL_NONE;
		stat.arc_end      = a_q >= NO_ARC;
		stat.bfs_new      = lev_v == LVL_NONE && res_rd != '0;
		stat.blk_ok       = lev_v == ulev1 && res_rd != '0;
		stat.v_sink       = tgt == cfg.sink_node;
		stat.can_push     = depth_q < DEPTH_W'(MAX_NODES);
		stat.lim_zero     = !stk_inf_q[top] && stk_lim_q[top] == '0;
		stat.last_frame   = depth_q == DEPTH_W'(1);
		rsp.max_flow      = sum_q > GOT_W'(FLOW_MAX) ? FLOW_MAX : sum_q[FLOW_W-1:0];
		rsp.edge_count    = 6'(arcs_q >> 1);
		rsp.status        = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arcs_q   <= '0;
			depth_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			sum_q    <= '0;
			status_q <= STS_OK;
			for (int i = 0; i < MAX_NODES; i++) begin
				first_q[i] <= NO_ARC;
				level_q[i] <= LVL_NONE;
			end
		end else begin
			case (op)
				OP_DECODE: begin
					sum_q    <= '0;
					status_q <= STS_OK;
					if (item_q.req_type == REQ_ADD) begin
						if (stat.add_bad) begin
							status_q <= STS_RANGE;
						end else if (stat.add_full) begin
							status_q <= STS_FULL;
						end
					end else if (item_q.req_type == REQ_RUN && stat.run_bad) begin
						status_q <= STS_RANGE;
					end
				end
				OP_ADD1: begin
					first_q[item_q.end_a] <= arcs_q;
					arcs_q <= arcs_q + 1'b1;
				end
				OP_ADD2: begin
					first_q[item_q.end_b] <= arcs_q;
					arcs_q <= arcs_q + 1'b1;
				end
				OP_CLEAR: begin
					arcs_q <= '0;
					for (int i = 0; i < MAX_NODES; i++) begin
						first_q[i] <= NO_ARC;
						level_q[i] <= LVL_NONE;
					end
				end
				OP_BFS_INIT: begin
					for (int i = 0; i < MAX_NODES; i++) begin
						level_q[i] <= LVL_NONE;
					end
					level_q[cfg.source_node] <= '0;
					head_q <= '0;
					tail_q <= DEPTH_W'(1);
				end
				OP_BFS_POP: begin
					if (!stat.q_empty) begin
						head_q <= head_q + 1'b1;
					end else if (stat.sink_reached) begin
						depth_q <= DEPTH_W'(1);
					end
				end
				OP_BFS_CHK: begin
					if (stat.bfs_new) begin
						level_q[tgt] <= ulev1;
						if (tail_q < DEPTH_W'(MAX_NODES)) begin
							tail_q <= tail_q + 1'b1;
						end
					end
				end
				OP_BLK_CHK: begin
					if (stat.blk_ok && !stat.v_sink && stat.can_push) begin
						depth_q <= depth_q + 1'b1;
					end
				end
				OP_POP: begin
					if (stk_got_q[top] == '0) begin
						level_q[stk_node_q[top]] <= LVL_DEAD;
					end
					depth_q <= depth_q - 1'b1;
					if (stat.last_frame) begin
						sum_q <= sum_q + stk_got_q[top];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				item_q <= item;
			end
			OP_BFS_INIT: begin
				queue_q[0] <= cfg.source_node;
			end
			OP_BFS_POP: begin
				if (!stat.q_empty) begin
					u_q    <= queue_q[head_q[NODE_W-1:0]];
					ulev_q <= level_q[queue_q[head_q[NODE_W-1:0]]];
					a_q    <= first_q[queue_q[head_q[NODE_W-1:0]]];
				end else if (stat.sink_reached) begin
					for (int i = 0; i < MAX_NODES; i++) begin
						cur_q[i] <= first_q[i];
					end
					stk_node_q[0] <= cfg.source_node;
					stk_lim_q[0]  <= '0;
					stk_inf_q[0]  <= 1'b1;
					stk_got_q[0]  <= '0;
				end
			end
			OP_BFS_CHK: begin
				if (stat.bfs_new && tail_q < DEPTH_W'(MAX_NODES)) begin
					queue_q[tail_q[NODE_W-1:0]] <= tgt;
				end
				a_q <= nxt;
			end
			OP_BLK_FRAME: begin
				u_q    <= pn_c;
				ulev_q <= level_q[pn_c];
				a_q    <= fa_c;
			end
			OP_BLK_CHK: begin
				if (stat.blk_ok && stat.v_sink) begin
					d_q      <= lim_eff;
					cur_q[u_q] <= a_q;
				end else if (stat.blk_ok && stat.can_push) begin
					stk_node_q[depth_q[NODE_W-1:0]] <= tgt;
					stk_lim_q[depth_q[NODE_W-1:0]]  <= lim_eff;
					stk_inf_q[depth_q[NODE_W-1:0]]  <= 1'b0;
					stk_got_q[depth_q[NODE_W-1:0]]  <= '0;
					cur_q[u_q] <= a_q;
				end else begin
					a_q <= nxt;
				end
			end
			OP_ARC_END: begin
				cur_q[u_q] <= a_q;
			end
			OP_POP: begin
				d_q <= stk_got_q[top][RES_W-1:0];
			end
			OP_U_RD1: begin
				pn_q <= pn_c;
				fa_q <= fa_c;
			end
			OP_U_WR1: begin
				stk_got_q[top] <= stk_got_q[top] + GOT_W'(d_q);
				if (!stk_inf_q[top]) begin
					stk_lim_q[top] <= stk_lim_q[top] - d_q;
				end
				a_q <= nxt;
			end
			OP_U_WR2: begin
				if (!stat.lim_zero) begin
					cur_q[pn_q] <= a_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== design/mflg_ctrl.sv =====
// mflg_ctrl: sequencer for add, clear and run requests; drives datapath ops.
// Depends on mflg_pkg.
module mflg_ctrl import mflg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  mflg_stat_t stat,
	output mflg_op_t   op,
	output logic       busy,
	output logic       done
);
	mflg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					op      = OP_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				op = OP_DECODE;
				case (stat.req_type)
					REQ_ADD:   state_d = (stat.add_bad || stat.add_full) ? S_RESP : S_ADD1;
					REQ_CLEAR: state_d = S_CLR;
					REQ_RUN:   state_d = (stat.run_bad || stat.run_same) ? S_RESP : S_BFS_INIT;
					default:   state_d = S_RESP;
				endcase
			end
			S_ADD1: begin
				op      = OP_ADD1;
				state_d = S_ADD2;
			end
			S_ADD2: begin
				op      = OP_ADD2;
				state_d = S_RESP;
			end
			S_CLR: begin
				op      = OP_CLEAR;
				state_d = S_RESP;
			end
			S_BFS_INIT: begin
				op      = OP_BFS_INIT;
				state_d = S_BFS_POP;
			end
			S_BFS_POP: begin
				op = OP_BFS_POP;
				if (!stat.q_empty) begin
					state_d = S_BFS_ARC;
				end else if (stat.sink_reached) begin
					state_d = S_BLK_FRAME;
				end else begin
					state_d = S_RESP;
				end
			end
			S_BFS_ARC: begin
				op      = OP_ARC_RD;
				state_d = stat.arc_end ? S_BFS_POP : S_BFS_CHK;
			end
			S_BFS_CHK: begin
				op      = OP_BFS_CHK;
				state_d = S_BFS_ARC;
			end
			S_BLK_FRAME: begin
				op      = OP_BLK_FRAME;
				state_d = S_BLK_ARC;
			end
			S_BLK_ARC: begin
				if (stat.arc_end) begin
					op      = OP_ARC_END;
					state_d = S_POP;
				end else begin
					op      = OP_ARC_RD;
					state_d = S_BLK_CHK;
				end
			end
			S_BLK_CHK: begin
				op = OP_BLK_CHK;
				if (stat.blk_ok && stat.v_sink) begin
					state_d = S_U_RD1;
				end else if (stat.blk_ok && stat.can_push) begin
					state_d = S_BLK_FRAME;
				end else begin
					state_d = S_BLK_ARC;
				end
			end
			S_POP: begin
				op      = OP_POP;
				state_d = stat.last_frame ? S_BFS_INIT : S_U_RD1;
			end
			S_U_RD1: begin
				op      = OP_U_RD1;
				state_d = S_U_WR1;
			end
			S_U_WR1: begin
				op      = OP_U_WR1;
				state_d = S_U_WR2;
			end
			S_U_WR2: begin
				op      = OP_U_WR2;
				state_d = stat.lim_zero ? S_POP : S_BLK_FRAME;
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== design/max_flow_level_graph.sv =====
// max_flow_level_graph: top level; APB register file, controller and datapath.
// Depends on mflg_pkg, mflg_ctrl, mflg_dp.
//
//  channel   handshake              transfer
//  request   start & !busy          item (mflg_req_t)
//  result    done, one cycle        result (mflg_rsp_t)
//  config    psel&penable&pwrite    pwdata at paddr, pready tied high
//
// Add: decode, then the writes of both arcs, then the response; clear: decode,
// a clearing step, then the response; rejected, unknown and same-terminal
// requests: decode, then the response. Run: BFS passes alternate with blocking
// passes; each reads the arcs one at a time through the arc memory read ports.
// Reset empties the graph at once; no clearing pass.
// done is not held back; the receiver takes it in that cycle.
module max_flow_level_graph import mflg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  mflg_req_t   item,
	output logic        done,
	output mflg_rsp_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	mflg_cfg_t  cfg_q;
	mflg_op_t   op;
	mflg_stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_node <= 4'd1;
			cfg_q.sink_node   <= 4'd7;
			cfg_q.node_count  <= 5'd8;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SOURCE: cfg_q.source_node <= pwdata[3:0];
				REG_SINK:   cfg_q.sink_node   <= pwdata[3:0];
				REG_NODES:  cfg_q.node_count  <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SOURCE: prdata = 32'(cfg_q.source_node);
			REG_SINK:   prdata = 32'(cfg_q.sink_node);
			REG_NODES:  prdata = 32'(cfg_q.node_count);
			default:    prdata = '0;
		endcase
	end

	mflg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.op(op), .busy(busy), .done(done)
	);

	mflg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .item(item), .cfg(cfg_q),
		.stat(stat), .rsp(result)
	);
endmodule

// ===== design/mflg_chk.sv =====
// mflg_chk: port-level assertions for max_flow_level_graph, bound to the top.
// Depends on mflg_pkg.
module mflg_chk import mflg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input mflg_rsp_t result
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held over two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted request not busy");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy) else $error("busy wrong around result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == STS_OK || result.status == STS_FULL ||
		          result.status == STS_RANGE)) else $error("bad status code");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.edge_count <= 6'(MAX_EDGES)) else $error("edge count too large");
endmodule

bind max_flow_level_graph mflg_chk u_mflg_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);
